### rtl/rrbm_pkg.sv
// Types and constants shared by the cartridge bank mapper modules.
// No dependencies.
`default_nettype none

package rrbm_pkg;

    localparam int OUT_ADDR_W = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BITS = 2'd1;

    localparam logic       OP_READ  = 1'b0;
    localparam logic       OP_WRITE = 1'b1;
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    localparam logic [1:0] SEL_RAM_ENABLE = 2'd0;
    localparam logic [1:0] SEL_LOW_BANK   = 2'd1;
    localparam logic [1:0] SEL_UPPER_BITS = 2'd2;
    localparam logic [1:0] SEL_MODE       = 2'd3;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2,
        TGT_REG  = 2'd3
    } t_target;

    typedef enum logic [2:0] {
        KIND_REG_WRITE,
        KIND_ROM_FIXED,
        KIND_ROM_BANKED,
        KIND_RAM,
        KIND_UNSUPPORTED
    } t_kind;

    typedef struct packed {
        logic        opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            target;
        logic [OUT_ADDR_W-1:0] physical_address;
        logic                  store_enable;
        logic [7:0]            store_data;
        logic                  unsupported;
    } t_out_item;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  sel;
        logic        is_write;
        logic [13:0] offset;
        logic [7:0]  data;
    } t_entry;

endpackage

`default_nettype wire

### rtl/rrbm_front.sv
// Front end of the bank mapper: sorts an incoming bus access by region.
// Depends on rrbm_pkg.
`default_nettype none

module rrbm_front (
    input  rrbm_pkg::t_in_item i_item,
    output rrbm_pkg::t_entry   o_entry
);

    always_comb begin
        o_entry.sel      = i_item.bus_address[14:13];
        o_entry.is_write = (i_item.opcode == rrbm_pkg::OP_WRITE);
        o_entry.offset   = i_item.bus_address[13:0];
        o_entry.data     = i_item.write_data;
        if (!i_item.bus_address[15]) begin
            if (i_item.opcode == rrbm_pkg::OP_WRITE) begin
                o_entry.kind = rrbm_pkg::KIND_REG_WRITE;
            end else if (i_item.bus_address[14]) begin
                o_entry.kind = rrbm_pkg::KIND_ROM_BANKED;
            end else begin
                o_entry.kind = rrbm_pkg::KIND_ROM_FIXED;
            end
        end else if (i_item.bus_address[15:13] == 3'b101) begin
            o_entry.kind = rrbm_pkg::KIND_RAM;
        end else begin
            o_entry.kind = rrbm_pkg::KIND_UNSUPPORTED;
        end
    end

endmodule

`default_nettype wire

### rtl/rrbm_queue.sv
// Two-entry queue between the front end and the back end of the bank mapper.
// Depends on rrbm_pkg.
`default_nettype none

module rrbm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rrbm_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output rrbm_pkg::t_entry o_entry
);

    rrbm_pkg::t_entry r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             n_wr_ptr;
    logic             n_rd_ptr;
    logic [1:0]       n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_entry   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, w_do_push} - {1'b0, w_do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

### rtl/rrbm_back.sv
// Back end of the bank mapper: holds the mapper and size registers, updates
// them in order and produces translated results. Depends on rrbm_pkg.
`default_nettype none

module rrbm_back #(
    parameter int ROM_ADDR_WIDTH = 21,
    parameter int RAM_ADDR_WIDTH = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rrbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrbm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_q_empty,
    input  rrbm_pkg::t_entry              i_q_entry,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_pop,
    output rrbm_pkg::t_out_item           o_result
);

    localparam logic [4:0] RomBitsMax = 5'(ROM_ADDR_WIDTH);
    localparam logic [3:0] RamBitsMax = 4'(RAM_ADDR_WIDTH);

    logic [4:0]          r_rom_bits;
    logic [3:0]          r_ram_bits;
    logic                r_ram_en;
    logic [4:0]          r_low_bank;
    logic [1:0]          r_upper;
    logic                r_mode;
    logic                r_out_valid;
    rrbm_pkg::t_out_item r_out;
    rrbm_pkg::t_out_item n_out;

    logic        w_take;
    logic        w_cfg_wr;
    logic [4:0]  w_rom_eff;
    logic [3:0]  w_ram_eff;
    logic [20:0] w_rom_mask;
    logic [14:0] w_ram_mask;
    logic [6:0]  w_bank;
    logic [20:0] w_rom_raw;
    logic [14:0] w_ram_raw;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_take      = !i_q_empty && (!r_out_valid || i_out_pop);
    assign o_q_pop     = w_take;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        w_rom_eff  = (r_rom_bits > RomBitsMax) ? RomBitsMax : r_rom_bits;
        w_ram_eff  = (r_ram_bits > RamBitsMax) ? RamBitsMax : r_ram_bits;
        w_rom_mask = ~(21'h1FFFFF << w_rom_eff);
        w_ram_mask = ~(15'h7FFF << w_ram_eff);
        w_bank     = r_mode ? {2'b00, r_low_bank} : {r_upper, r_low_bank};
        if (i_q_entry.kind == rrbm_pkg::KIND_ROM_BANKED) begin
            w_rom_raw = {w_bank, i_q_entry.offset};
        end else begin
            w_rom_raw = {7'd0, i_q_entry.offset};
        end
        w_ram_raw = {(r_mode ? r_upper : 2'b00), i_q_entry.offset[12:0]};

        n_out = '0;
        case (i_q_entry.kind)
            rrbm_pkg::KIND_REG_WRITE: begin
                n_out.target = rrbm_pkg::TGT_REG;
            end
            rrbm_pkg::KIND_ROM_FIXED, rrbm_pkg::KIND_ROM_BANKED: begin
                n_out.target           = rrbm_pkg::TGT_ROM;
                n_out.physical_address = w_rom_raw & w_rom_mask;
            end
            rrbm_pkg::KIND_RAM: begin
                if (r_ram_en && (r_ram_bits != 4'd0)) begin
                    n_out.target           = rrbm_pkg::TGT_RAM;
                    n_out.physical_address = {6'd0, w_ram_raw & w_ram_mask};
                    n_out.store_enable     = i_q_entry.is_write;
                    n_out.store_data       = i_q_entry.is_write ? i_q_entry.data : 8'd0;
                end
            end
            default: begin
                n_out.unsupported = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bits <= 5'd15;
            r_ram_bits <= 4'd0;
        end else if (w_cfg_wr) begin
            if (i_cfg_index == rrbm_pkg::CFG_ROM_BITS) begin
                r_rom_bits <= i_cfg_data;
            end else if (i_cfg_index == rrbm_pkg::CFG_RAM_BITS) begin
                r_ram_bits <= i_cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_en   <= 1'b0;
            r_low_bank <= 5'd0;
            r_upper    <= 2'd0;
            r_mode     <= 1'b0;
        end else if (w_take && i_q_entry.kind == rrbm_pkg::KIND_REG_WRITE) begin
            case (i_q_entry.sel)
                rrbm_pkg::SEL_RAM_ENABLE: begin
                    r_ram_en <= (i_q_entry.data[3:0] == rrbm_pkg::RAM_ENABLE_KEY);
                end
                rrbm_pkg::SEL_LOW_BANK: begin
                    r_low_bank <= i_q_entry.data[4:0];
                end
                rrbm_pkg::SEL_UPPER_BITS: begin
                    r_upper <= i_q_entry.data[1:0];
                end
                default: begin
                    r_mode <= i_q_entry.data[0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    a_store_only_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.store_enable |-> r_out.target == rrbm_pkg::TGT_RAM)
        else $error("store enable set on a result that does not target RAM");

    a_no_addr_without_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.target == rrbm_pkg::TGT_NONE
                        || r_out.target == rrbm_pkg::TGT_REG)
        |-> r_out.physical_address == '0)
        else $error("address set on a result with no memory target");

    a_mode_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && i_q_entry.kind == rrbm_pkg::KIND_REG_WRITE
        && i_q_entry.sel == rrbm_pkg::SEL_MODE |=> r_mode == $past(i_q_entry.data[0]))
        else $error("banking mode not updated by a mode register write");

    a_no_take_while_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_pop |-> !o_q_pop)
        else $error("queue entry consumed while the result slot is occupied");

endmodule

`default_nettype wire

### rtl/rom_ram_bank_mapper_two_mode_unit.sv
// Top level of the cartridge bank mapper.
// Depends on rrbm_pkg, rrbm_front, rrbm_queue and rrbm_back.
//
// Usage: bus accesses enter through a queue-style port; a transaction is
// taken on a clock edge with i_push high and o_full low. Each access gives
// exactly one result, presented while o_empty is low and taken on an edge
// with i_pop high. Results leave in the order the accesses came in.
// The front end sorts each access by region and writes it into a two-entry
// queue; the back end applies mapper register writes in order and computes
// the wrapped ROM or RAM byte address into a result register.
// Each access passes through the queue into the result register. Throughput is one
// transaction per cycle while the receiver pops every result; the back end takes a
// queued entry whenever the result register is empty or being popped in the same
// cycle. When the receiver stalls, the result register holds, the queue fills and
// o_full rises after two more transactions. The size registers are written through
// the cfg port (index 0 ROM size, index 1 RAM size), ready at all times; the user
// must write them only while no transaction is in flight, as the block does not
// enforce this. Synchronous reset empties the queue and result register, disables
// RAM, clears the bank and mode registers and sets a 32 KiB ROM with no RAM.
`default_nettype none

module rom_ram_bank_mapper_two_mode_unit #(
    parameter int ROM_ADDR_WIDTH = 21,
    parameter int RAM_ADDR_WIDTH = 15
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  rrbm_pkg::t_in_item              i_item,
    output logic                            o_empty,
    input  logic                            i_pop,
    output rrbm_pkg::t_out_item             o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rrbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rrbm_pkg::t_entry w_front_entry;
    rrbm_pkg::t_entry w_head_entry;
    logic             w_q_empty;
    logic             w_q_pop;
    logic             w_out_valid;

    rrbm_front u_front (
        .i_item  (i_item),
        .o_entry (w_front_entry)
    );

    rrbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_entry (w_front_entry),
        .o_full  (o_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_entry (w_head_entry)
    );

    rrbm_back #(
        .ROM_ADDR_WIDTH (ROM_ADDR_WIDTH),
        .RAM_ADDR_WIDTH (RAM_ADDR_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (w_q_empty),
        .i_q_entry   (w_head_entry),
        .o_q_pop     (w_q_pop),
        .o_out_valid (w_out_valid),
        .i_out_pop   (i_pop),
        .o_result    (o_result)
    );

    assign o_empty = !w_out_valid;

endmodule

`default_nettype wire

### bench/rom_ram_bank_mapper_two_mode_unit_test.sv
// Self-checking testbench for the cartridge bank mapper top level, driving
// directed and random bus accesses with random gaps and stalls on both sides.
// Depends on rrbm_pkg and rom_ram_bank_mapper_two_mode_unit.
module rom_ram_bank_mapper_two_mode_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rrbm_pkg::*;

    localparam int ROM_W = 21;
    localparam int RAM_W = 15;
    localparam int MAX_GAP = 11;
    localparam int REPORT_CAP = 50;

    localparam logic [15:0] LOW_BANK_BASE   = 16'h2000;
    localparam logic [15:0] ROM_BANKED_BASE = 16'h4000;
    localparam logic [15:0] MODE_BASE       = 16'h6000;
    localparam logic [15:0] RAM_WINDOW_BASE = 16'hA000;
    localparam logic [15:0] RAM_WINDOW_END  = 16'hC000;
    localparam logic [15:0] REG_WINDOW_END  = 16'h8000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_push;
    logic      o_full;
    t_in_item  i_item;
    logic      o_empty;
    logic      i_pop;
    t_out_item o_result;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rom_ram_bank_mapper_two_mode_unit #(
        .ROM_ADDR_WIDTH(ROM_W),
        .RAM_ADDR_WIDTH(RAM_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(i_push),
        .o_full(o_full),
        .i_item(i_item),
        .o_empty(o_empty),
        .i_pop(i_pop),
        .o_result(o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the mapper registers and the size settings.
    logic [4:0] rom_size_bits;
    logic [3:0] ram_size_bits;
    logic       ram_on;
    logic [4:0] bank_lo;
    logic [1:0] bank_hi;
    logic       bank_mode;

    t_out_item   pending_translations[$];
    int unsigned mismatch_count;
    bit          fast_tx;
    bit          fast_rx;
    int unsigned rx_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [OUT_ADDR_W-1:0] wrap_to_size(logic [31:0] raw,
                                                          int unsigned bits,
                                                          int unsigned cap);
        int unsigned eff;
        eff = (bits > cap) ? cap : bits;
        return OUT_ADDR_W'(raw & ((32'd1 << eff) - 32'd1));
    endfunction

    function automatic t_out_item translate_access(t_in_item acc);
        t_out_item   r;
        logic [31:0] raw;
        logic [6:0]  bank;
        r = '0;
        if (acc.bus_address < REG_WINDOW_END) begin
            if (acc.opcode == OP_WRITE) begin
                if (acc.bus_address < LOW_BANK_BASE) begin
                    ram_on = (acc.write_data[3:0] == RAM_ENABLE_KEY);
                end else if (acc.bus_address < ROM_BANKED_BASE) begin
                    bank_lo = acc.write_data[4:0];
                end else if (acc.bus_address < MODE_BASE) begin
                    bank_hi = acc.write_data[1:0];
                end else begin
                    bank_mode = acc.write_data[0];
                end
                r.target = TGT_REG;
            end else begin
                if (acc.bus_address < ROM_BANKED_BASE) begin
                    raw = 32'(acc.bus_address);
                end else begin
                    bank = bank_mode ? {2'b00, bank_lo} : {bank_hi, bank_lo};
                    raw = {11'd0, bank, acc.bus_address[13:0]};
                end
                r.target = TGT_ROM;
                r.physical_address = wrap_to_size(raw, rom_size_bits, ROM_W);
            end
        end else if (acc.bus_address >= RAM_WINDOW_BASE && acc.bus_address < RAM_WINDOW_END) begin
            if (ram_on && ram_size_bits != 4'd0) begin
                raw = 32'(acc.bus_address - RAM_WINDOW_BASE);
                if (bank_mode) begin
                    raw = raw + (32'(bank_hi) << 13);
                end
                r.target = TGT_RAM;
                r.physical_address = wrap_to_size(raw, ram_size_bits, RAM_W);
                if (acc.opcode == OP_WRITE) begin
                    r.store_enable = 1'b1;
                    r.store_data = acc.write_data;
                end
            end
        end else begin
            r.unsupported = 1'b1;
        end
        return r;
    endfunction

    function automatic t_in_item build_access(logic op, logic [15:0] addr, logic [7:0] data);
        t_in_item a;
        a.opcode = op;
        a.bus_address = addr;
        a.write_data = data;
        return a;
    endfunction

    // Mostly well-formed traffic: register writes, ROM and RAM accesses, some noise.
    function automatic t_in_item random_access();
        t_in_item    a;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        a.opcode = 1'($urandom_range(0, 1));
        a.write_data = 8'($urandom);
        if (pick < 30) begin
            a.opcode = OP_WRITE;
            a.bus_address = 16'($urandom_range(0, 16'h7FFF));
            if (a.bus_address < LOW_BANK_BASE && $urandom_range(0, 9) < 7) begin
                a.write_data[3:0] = RAM_ENABLE_KEY;
            end
        end else if (pick < 60) begin
            a.opcode = OP_READ;
            a.bus_address = 16'($urandom_range(0, 16'h7FFF));
        end else if (pick < 88) begin
            a.bus_address = 16'($urandom_range(RAM_WINDOW_BASE, RAM_WINDOW_END - 1));
        end else begin
            a.bus_address = 16'($urandom);
        end
        return a;
    endfunction

    function automatic int unsigned draw_gap(bit fast);
        return fast ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP) begin
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        end
    endtask

    task automatic check_translation(t_out_item got);
        t_out_item want;
        if (pending_translations.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(got), 32'd0);
            return;
        end
        want = pending_translations.pop_front();
        if (got.target !== want.target) begin
            report_mismatch("target", 32'(got.target), 32'(want.target));
        end
        if (got.physical_address !== want.physical_address) begin
            report_mismatch("physical_address", 32'(got.physical_address),
                            32'(want.physical_address));
        end
        if (got.store_enable !== want.store_enable) begin
            report_mismatch("store_enable", 32'(got.store_enable), 32'(want.store_enable));
        end
        if (got.store_data !== want.store_data) begin
            report_mismatch("store_data", 32'(got.store_data), 32'(want.store_data));
        end
        if (got.unsupported !== want.unsupported) begin
            report_mismatch("unsupported", 32'(got.unsupported), 32'(want.unsupported));
        end
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        int unsigned stall;
        bit          taken;
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_gap(fast_rx);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                i_pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            taken = 1'b0;
            while (!taken) begin
                @(posedge i_clk);
                if (!o_empty) begin
                    check_translation(o_result);
                    taken = 1'b1;
                end
                @(negedge i_clk);
            end
        end
    end

    task automatic send_access(t_in_item acc);
        int unsigned gap;
        bit          taken;
        gap = draw_gap(fast_tx);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= acc;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!o_full) begin
                pending_translations.push_back(translate_access(acc));
                taken = 1'b1;
            end
            @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        while (pending_translations.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (o_cfg_ready) begin
                if (idx == CFG_ROM_BITS) begin
                    rom_size_bits = data;
                end else if (idx == CFG_RAM_BITS) begin
                    ram_size_bits = data[3:0];
                end
                taken = 1'b1;
            end
            @(negedge i_clk);
        end
    endtask

    task automatic change_sizes(logic [4:0] rom_bits, logic [3:0] ram_bits);
        wait_drained();
        cfg_write(CFG_ROM_BITS, rom_bits);
        cfg_write(CFG_RAM_BITS, CFG_DATA_W'(ram_bits));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_access(build_access(OP_READ, 16'h4000, 8'h00));
        send_access(build_access(OP_READ, 16'hFFFF, 8'h00));
        send_access(build_access(OP_WRITE, 16'h8000, 8'hFF));
        send_access(build_access(OP_WRITE, 16'h0000, 8'h0A));
        send_access(build_access(OP_READ, 16'hA000, 8'h00));
    endtask

    task automatic test_register_map();
        change_sizes(5'd21, 4'd15);
        send_access(build_access(OP_WRITE, 16'h1FFF, 8'hFA));
        send_access(build_access(OP_WRITE, 16'h2000, 8'hFF));
        send_access(build_access(OP_WRITE, 16'h5FFF, 8'hFF));
        send_access(build_access(OP_READ, 16'h7FFF, 8'h00));
        send_access(build_access(OP_READ, 16'h3FFF, 8'h00));
        send_access(build_access(OP_READ, 16'h0000, 8'h00));
        send_access(build_access(OP_WRITE, 16'hA000, 8'hFF));
        send_access(build_access(OP_READ, 16'hBFFF, 8'h00));
        send_access(build_access(OP_WRITE, 16'h6000, 8'h01));
        send_access(build_access(OP_READ, 16'h4000, 8'h00));
        send_access(build_access(OP_WRITE, 16'hBFFF, 8'h00));
        send_access(build_access(OP_WRITE, 16'h7FFF, 8'hFE));
        send_access(build_access(OP_WRITE, 16'h3FFF, 8'h00));
        send_access(build_access(OP_WRITE, 16'h4000, 8'h00));
        send_access(build_access(OP_READ, 16'h4000, 8'h00));
        send_access(build_access(OP_WRITE, 16'h0000, 8'h0B));
        send_access(build_access(OP_WRITE, 16'hA123, 8'h55));
        send_access(build_access(OP_READ, 16'h9FFF, 8'h00));
        send_access(build_access(OP_READ, 16'hC000, 8'h00));
    endtask

    task automatic test_size_sweep();
        logic [4:0] rom_steps[8] = '{5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd31};
        logic [3:0] ram_steps[8] = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd11, 4'd13, 4'd15, 4'd14};
        foreach (rom_steps[k]) begin
            change_sizes(rom_steps[k], ram_steps[k]);
            repeat (60) send_access(random_access());
        end
    endtask

    task automatic test_backpressure();
        change_sizes(5'd21, 4'd15);
        fast_tx = 1'b1;
        rx_hold_cycles = 150;
        repeat (40) send_access(random_access());
        fast_tx = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 700; n++) begin
            if (n % 64 == 0) begin
                fast_tx = ($urandom_range(0, 3) == 0);
                fast_rx = ($urandom_range(0, 3) == 0);
            end
            send_access(random_access());
        end
        fast_tx = 1'b0;
        fast_rx = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        rom_size_bits = 5'd15;
        ram_size_bits = 4'd0;
        ram_on = 1'b0;
        bank_lo = 5'd0;
        bank_hi = 2'd0;
        bank_mode = 1'b0;
        mismatch_count = 0;
        fast_tx = 1'b0;
        fast_rx = 1'b0;
        rx_hold_cycles = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_register_map();
        test_size_sweep();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && pending_translations.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
